// ===== rtl/lwd_pkg.sv =====
// Shared types and constants for the liveness watchdog.
// No dependencies.
package lwd_pkg;

    localparam int MODULES = 3;
    localparam int IDX_W   = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam int MOD_W   = 2;
    localparam int TIME_W  = 32;
    localparam int TMO_REGS = 3;
    localparam int MASK_W  = 3;

    localparam logic [MOD_W-1:0] NO_MODULE = 2'd3;

    localparam logic CMD_KICK  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    localparam logic [1:0] REG_TMO0     = 2'd0;
    localparam logic [1:0] REG_TMO1     = 2'd1;
    localparam logic [1:0] REG_TMO2     = 2'd2;
    localparam logic [1:0] REG_COOLDOWN = 2'd3;

    localparam logic [TIME_W-1:0] TMO0_RST     = 32'd6000;
    localparam logic [TIME_W-1:0] TMO1_RST     = 32'd6000;
    localparam logic [TIME_W-1:0] TMO2_RST     = 32'd10000;
    localparam logic [TIME_W-1:0] COOLDOWN_RST = 32'd900000;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_EV   = 4'b0100,
        ST_FIN  = 4'b1000
    } lwd_state_t;

    typedef struct packed {
        logic              kick_we;
        logic              start_we;
        logic              rearm;
        logic [IDX_W-1:0]  addr;
        logic [TIME_W-1:0] data;
    } lwd_wr_t;

endpackage

// ===== rtl/lwd_store.sv =====
// Time store: kick time and degrade start per module in two memories.
// Uses lwd_pkg. Valid bits plus a base time model reset and re-arm.
module lwd_store
    import lwd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  rd_addr,
    input  lwd_wr_t           wr,
    output logic [TIME_W-1:0] kick_time,
    output logic [TIME_W-1:0] degrade_start
);

    logic [TIME_W-1:0] kick_mem  [0:MODULES-1];
    logic [TIME_W-1:0] start_mem [0:MODULES-1];

    logic [TIME_W-1:0]  kick_rd_reg;
    logic [TIME_W-1:0]  start_rd_reg;
    logic               kvalid_rd_reg;
    logic               svalid_rd_reg;
    logic [MODULES-1:0] kvalid_reg;
    logic [MODULES-1:0] svalid_reg;
    logic [TIME_W-1:0]  base_reg;

    always_ff @(posedge clk)
    begin
        if (wr.kick_we)
        begin
            kick_mem[wr.addr] <= wr.data;
        end
        if (wr.start_we)
        begin
            start_mem[wr.addr] <= wr.data;
        end
        kick_rd_reg  <= kick_mem[rd_addr];
        start_rd_reg <= start_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kvalid_reg    <= '0;
            svalid_reg    <= '0;
            kvalid_rd_reg <= 1'b0;
            svalid_rd_reg <= 1'b0;
            base_reg      <= '0;
        end
        else
        begin
            kvalid_rd_reg <= kvalid_reg[rd_addr];
            svalid_rd_reg <= svalid_reg[rd_addr];
            if (wr.rearm)
            begin
                kvalid_reg <= '0;
                svalid_reg <= '0;
                base_reg   <= wr.data;
            end
            else
            begin
                if (wr.kick_we)
                begin
                    kvalid_reg[wr.addr] <= 1'b1;
                end
                if (wr.start_we)
                begin
                    svalid_reg[wr.addr] <= 1'b1;
                end
            end
        end
    end

    assign kick_time     = kvalid_rd_reg ? kick_rd_reg : base_reg;
    assign degrade_start = svalid_rd_reg ? start_rd_reg : base_reg;

endmodule

// ===== rtl/multi_module_liveness_watchdog_core.sv =====
// Liveness watchdog core: kick and check items, config registers, scan sequencer.
// Uses lwd_pkg and lwd_store.
//
// One item at a time. With the result side free, a kick goes from acceptance
// through the final state back to idle, ready for the next item. A check reads
// and then evaluates each module in turn and ends in the final state; it ends
// early when a reboot ends the scan. Each module costs one read and one evaluate
// state on the single read port of the time store. The result sits in an output
// register, so the next item is taken while it waits. If that result is still
// stalled when the next item finishes, the core holds in its final state and
// takes no new item until the output register frees. Register writes are taken
// in any cycle (ready is always high).
module multi_module_liveness_watchdog_core
    import lwd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic              command,
    input  logic [MOD_W-1:0]  module_req,
    input  logic [TIME_W-1:0] now_ms,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              reboot,
    output logic [MOD_W-1:0]  reboot_module,
    output logic [MASK_W-1:0] error_mask,
    output logic [MOD_W-1:0]  remembered_failure,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [TIME_W-1:0] cfg_data
);

    lwd_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic               rb_reg, rb_next;
    logic [MOD_W-1:0]   rbmod_reg, rbmod_next;
    logic [MODULES-1:0] degraded_reg, degraded_next;
    logic [MOD_W-1:0]   failed_reg, failed_next;
    logic [TIME_W-1:0]  timeout_reg [0:TMO_REGS-1];
    logic [TIME_W-1:0]  cooldown_reg;

    logic               ovalid_reg, ovalid_next;
    logic               orb_reg, orb_next;
    logic [MOD_W-1:0]   ormod_reg, ormod_next;
    logic [MASK_W-1:0]  omask_reg, omask_next;
    logic [MOD_W-1:0]   ofail_reg, ofail_next;

    lwd_wr_t            wr;
    logic [TIME_W-1:0]  st_kick;
    logic [TIME_W-1:0]  st_start;
    logic               accept;
    logic               late;
    logic               cool;
    logic               is_failed;
    logic [TIME_W-1:0]  start_eff;

    lwd_store u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .rd_addr       (idx_reg),
        .wr            (wr),
        .kick_time     (st_kick),
        .degrade_start (st_start)
    );

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    assign late      = (now_reg - st_kick) > timeout_reg[idx_reg];
    assign is_failed = (failed_reg == MOD_W'(idx_reg));
    assign start_eff = degraded_reg[idx_reg] ? st_start : now_reg;
    assign cool      = (now_reg - start_eff) > cooldown_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        now_next      = now_reg;
        rb_next       = rb_reg;
        rbmod_next    = rbmod_reg;
        degraded_next = degraded_reg;
        failed_next   = failed_reg;
        ovalid_next   = ovalid_reg && result_stall;
        orb_next      = orb_reg;
        ormod_next    = ormod_reg;
        omask_next    = omask_reg;
        ofail_next    = ofail_reg;
        wr            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    now_next   = now_ms;
                    idx_next   = '0;
                    rb_next    = 1'b0;
                    rbmod_next = '0;
                    if (command == CMD_CHECK)
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        wr.kick_we = (module_req < MOD_W'(MODULES));
                        wr.addr    = module_req[IDX_W-1:0];
                        wr.data    = now_ms;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_EV;
            end
            ST_EV:
            begin
                wr.addr = idx_reg;
                wr.data = now_reg;
                if (!late)
                begin
                    degraded_next[idx_reg] = 1'b0;
                    if (is_failed)
                    begin
                        failed_next = NO_MODULE;
                    end
                end
                else if (is_failed && !cool)
                begin
                    if (!degraded_reg[idx_reg])
                    begin
                        degraded_next[idx_reg] = 1'b1;
                        wr.start_we            = 1'b1;
                    end
                end
                if (late && (!is_failed || cool))
                begin
                    rb_next       = 1'b1;
                    rbmod_next    = MOD_W'(idx_reg);
                    failed_next   = MOD_W'(idx_reg);
                    degraded_next = '0;
                    wr.rearm      = 1'b1;
                    state_next    = ST_FIN;
                end
                else if (idx_reg == IDX_W'(MODULES - 1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_FIN:
            begin
                if (!ovalid_reg || !result_stall)
                begin
                    ovalid_next = 1'b1;
                    orb_next    = rb_reg;
                    ormod_next  = rbmod_reg;
                    omask_next  = MASK_W'(degraded_reg);
                    ofail_next  = failed_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            degraded_reg   <= '0;
            failed_reg     <= NO_MODULE;
            ovalid_reg     <= 1'b0;
            timeout_reg[0] <= TMO0_RST;
            timeout_reg[1] <= TMO1_RST;
            timeout_reg[2] <= TMO2_RST;
            cooldown_reg   <= COOLDOWN_RST;
        end
        else
        begin
            state_reg    <= state_next;
            degraded_reg <= degraded_next;
            failed_reg   <= failed_next;
            ovalid_reg   <= ovalid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TMO0:     timeout_reg[0] <= cfg_data;
                    REG_TMO1:     timeout_reg[1] <= cfg_data;
                    REG_TMO2:     timeout_reg[2] <= cfg_data;
                    REG_COOLDOWN: cooldown_reg   <= cfg_data;
                    default:      cooldown_reg   <= cooldown_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        now_reg   <= now_next;
        rb_reg    <= rb_next;
        rbmod_reg <= rbmod_next;
        orb_reg   <= orb_next;
        ormod_reg <= ormod_next;
        omask_reg <= omask_next;
        ofail_reg <= ofail_next;
    end

    assign result_valid       = ovalid_reg;
    assign reboot             = orb_reg;
    assign reboot_module      = ormod_reg;
    assign error_mask         = omask_reg;
    assign remembered_failure = ofail_reg;

endmodule

// ===== sim/tb_multi_module_liveness_watchdog_core.sv =====
// Testbench for multi_module_liveness_watchdog_core: directed table, then random soak phases,
// each result checked against its typed row or in-bench predictor, random idling both sides.
// Depends on rtl/lwd_pkg.sv, rtl/lwd_store.sv and rtl/multi_module_liveness_watchdog_core.sv.
`timescale 1ns / 1ps

module tb_multi_module_liveness_watchdog_core;
    import lwd_pkg::*;

    localparam int DIR_ROWS     = 22;
    localparam int PHASES       = 8;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic              reboot;
        logic [MOD_W-1:0]  reboot_module;
        logic [MASK_W-1:0] error_mask;
        logic [MOD_W-1:0]  remembered_failure;
    } wd_status_t;

    typedef struct {
        logic              cmd;
        logic [MOD_W-1:0]  mod;
        logic [TIME_W-1:0] stamp;
        bit                typed;
        wd_status_t        status;
    } dir_row_t;

    typedef struct {
        logic [TIME_W-1:0] tmo0;
        logic [TIME_W-1:0] tmo1;
        logic [TIME_W-1:0] tmo2;
        logic [TIME_W-1:0] cool;
        int unsigned       cap;
        int                items;
        bit                calm;
    } soak_phase_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    logic              command      = CMD_KICK;
    logic [MOD_W-1:0]  module_req   = '0;
    logic [TIME_W-1:0] now_ms       = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              reboot;
    logic [MOD_W-1:0]  reboot_module;
    logic [MASK_W-1:0] error_mask;
    logic [MOD_W-1:0]  remembered_failure;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index    = REG_TMO0;
    logic [TIME_W-1:0] cfg_data     = '0;

    // predictor state and configuration
    logic [TIME_W-1:0] kick_t     [MODULES];
    logic              degr       [MODULES];
    logic [TIME_W-1:0] degr_start [MODULES];
    logic [MOD_W-1:0]  failed;
    logic [TIME_W-1:0] limit_t    [MODULES];
    logic [TIME_W-1:0] cooldown;

    wd_status_t  pending_status [$];
    int          mismatch_cnt = 0;
    int unsigned item_gap     = 0;
    bit          calm         = 1'b0;

    always #2 clk = ~clk;

    multi_module_liveness_watchdog_core i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .item_valid         (item_valid),
        .item_stall         (item_stall),
        .command            (command),
        .module_req         (module_req),
        .now_ms             (now_ms),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .reboot             (reboot),
        .reboot_module      (reboot_module),
        .error_mask         (error_mask),
        .remembered_failure (remembered_failure),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    function automatic wd_status_t watchdog_scan(input logic cmd, input logic [MOD_W-1:0] mr,
                                                 input logic [TIME_W-1:0] now);
        wd_status_t        r;
        logic [TIME_W-1:0] age;
        bit                hit;
        r   = '0;
        hit = 1'b0;
        if (cmd == CMD_KICK) begin
            if (mr < MODULES)
                kick_t[mr] = now;
        end
        else begin
            for (int i = 0; i < MODULES; i++) begin
                if (!hit) begin
                    age = now - kick_t[i];
                    if (age <= limit_t[i]) begin
                        degr[i] = 1'b0;
                        if (failed == i)
                            failed = NO_MODULE;
                    end
                    else begin
                        if (failed == i) begin
                            if (!degr[i]) begin
                                degr[i]       = 1'b1;
                                degr_start[i] = now;
                            end
                            age = now - degr_start[i];
                            hit = (age > cooldown);
                        end
                        else
                            hit = 1'b1;
                        if (hit) begin
                            r.reboot        = 1'b1;
                            r.reboot_module = i[MOD_W-1:0];
                            failed          = i[MOD_W-1:0];
                            for (int k = 0; k < MODULES; k++) begin
                                kick_t[k]     = now;
                                degr_start[k] = now;
                                degr[k]       = 1'b0;
                            end
                        end
                    end
                end
            end
        end
        for (int i = 0; i < MODULES; i++)
            r.error_mask[i] = degr[i];
        r.remembered_failure = failed;
        return r;
    endfunction

    task automatic send_item(input logic cmd, input logic [MOD_W-1:0] mr,
                             input logic [TIME_W-1:0] now, input bit typed,
                             input wd_status_t typed_res);
        wd_status_t predicted;
        if (item_gap > 0) begin
            item_valid <= 1'b0;
            repeat (item_gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        command    <= cmd;
        module_req <= mr;
        now_ms     <= now;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predicted = watchdog_scan(cmd, mr, now);
        pending_status.push_back(typed ? typed_res : predicted);
        item_gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    endtask

    task automatic drain_results();
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_limits(input logic [TIME_W-1:0] t0, input logic [TIME_W-1:0] t1,
                               input logic [TIME_W-1:0] t2, input logic [TIME_W-1:0] cd);
        logic [1:0]        sel  [4];
        logic [TIME_W-1:0] vals [4];
        sel  = '{REG_TMO0, REG_TMO1, REG_TMO2, REG_COOLDOWN};
        vals = '{t0, t1, t2, cd};
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= sel[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (sel[k])
                REG_TMO0:     limit_t[0] = vals[k];
                REG_TMO1:     limit_t[1] = vals[k];
                REG_TMO2:     limit_t[2] = vals[k];
                REG_COOLDOWN: cooldown   = vals[k];
                default:      ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        dir_row_t          dir_tab [DIR_ROWS];
        soak_phase_t       phases  [PHASES];
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] stamp;
        logic [MOD_W-1:0]  mr;
        logic              cmd;
        int unsigned       sel;
        int unsigned       m;
        int unsigned       victim;

        for (int i = 0; i < MODULES; i++) begin
            kick_t[i]     = '0;
            degr[i]       = 1'b0;
            degr_start[i] = '0;
        end
        failed     = NO_MODULE;
        limit_t[0] = TMO0_RST;
        limit_t[1] = TMO1_RST;
        limit_t[2] = TMO2_RST;
        cooldown   = COOLDOWN_RST;

        dir_tab[0]  = '{CMD_CHECK, 2'd0, 32'd0,          1'b1, {1'b0, 2'd0, 3'd0, NO_MODULE}};
        dir_tab[1]  = '{CMD_KICK,  2'd3, 32'hFFFF_FFFF,  1'b1, {1'b0, 2'd0, 3'd0, NO_MODULE}};
        dir_tab[2]  = '{CMD_CHECK, 2'd0, 32'd6000,       1'b1, {1'b0, 2'd0, 3'd0, NO_MODULE}};
        dir_tab[3]  = '{CMD_CHECK, 2'd0, 32'd6001,       1'b1, {1'b1, 2'd0, 3'd0, 2'd0}};
        dir_tab[4]  = '{CMD_KICK,  2'd1, 32'd12000,      1'b0, '0};
        dir_tab[5]  = '{CMD_KICK,  2'd2, 32'd12000,      1'b0, '0};
        dir_tab[6]  = '{CMD_CHECK, 2'd0, 32'd12002,      1'b0, '0};
        dir_tab[7]  = '{CMD_KICK,  2'd1, 32'd912000,     1'b0, '0};
        dir_tab[8]  = '{CMD_KICK,  2'd2, 32'd912000,     1'b0, '0};
        dir_tab[9]  = '{CMD_CHECK, 2'd0, 32'd912002,     1'b0, '0};
        dir_tab[10] = '{CMD_CHECK, 2'd0, 32'd912003,     1'b0, '0};
        dir_tab[11] = '{CMD_KICK,  2'd0, 32'd912100,     1'b0, '0};
        dir_tab[12] = '{CMD_CHECK, 2'd0, 32'd912100,     1'b0, '0};
        dir_tab[13] = '{CMD_KICK,  2'd0, 32'hFFFF_FFF0,  1'b0, '0};
        dir_tab[14] = '{CMD_KICK,  2'd1, 32'hFFFF_FFF0,  1'b0, '0};
        dir_tab[15] = '{CMD_KICK,  2'd2, 32'hFFFF_FFF0,  1'b0, '0};
        dir_tab[16] = '{CMD_CHECK, 2'd0, 32'h0000_1000,  1'b0, '0};
        dir_tab[17] = '{CMD_CHECK, 2'd3, 32'hFFFF_FFFF,  1'b0, '0};
        dir_tab[18] = '{CMD_KICK,  2'd0, 32'h0000_1800,  1'b0, '0};
        dir_tab[19] = '{CMD_CHECK, 2'd0, 32'h0000_1800,  1'b0, '0};
        dir_tab[20] = '{CMD_KICK,  2'd2, 32'h8000_0000,  1'b0, '0};
        dir_tab[21] = '{CMD_CHECK, 2'd1, 32'h8000_0000,  1'b0, '0};

        phases[0] = '{TMO0_RST, TMO1_RST, TMO2_RST, COOLDOWN_RST, 4000, 200, 1'b0};
        phases[1] = '{32'd100, 32'd150, 32'd200, 32'd300, 120, 250, 1'b0};
        phases[2] = '{32'd0, 32'd0, 32'd0, 32'd0, 3, 150, 1'b0};
        phases[3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      1000, 100, 1'b0};
        phases[4] = '{32'd0, 32'hFFFF_FFFF, 32'd50, 32'd20, 60, 200, 1'b0};
        phases[5] = '{$urandom_range(1, 500), $urandom_range(1, 500), $urandom_range(1, 500),
                      $urandom_range(0, 2000), 300, 250, 1'b1};
        phases[6] = '{$urandom, $urandom, $urandom, $urandom, 32'hFFFF_FFFF, 100, 1'b0};
        phases[7] = '{32'd30, 32'd30, 32'd30, 32'd100, 40, 150, 1'b0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_item(dir_tab[r].cmd, dir_tab[r].mod, dir_tab[r].stamp,
                      dir_tab[r].typed, dir_tab[r].status);
        item_valid <= 1'b0;

        clock_ms = $urandom;
        victim   = 32'(NO_MODULE);
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            calm = phases[p].calm;
            load_limits(phases[p].tmo0, phases[p].tmo1, phases[p].tmo2, phases[p].cool);
            for (int n = 0; n < phases[p].items; n++) begin
                if ($urandom_range(0, 19) == 0)
                    victim = $urandom_range(0, 3);
                m = $urandom_range(0, MODULES - 1);
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    stamp = $urandom;
                else if (sel == 1)
                    stamp = kick_t[m] + limit_t[m] + $urandom_range(0, 1);
                else if (sel == 2)
                    stamp = degr_start[m] + cooldown + $urandom_range(0, 1);
                else if (sel == 3)
                    stamp = clock_ms;
                else
                    stamp = clock_ms + $urandom_range(0, phases[p].cap);
                if (stamp - clock_ms < 32'h8000_0000)
                    clock_ms = stamp;
                // mostly keep the modules other than the victim alive
                sel = $urandom_range(0, 99);
                if (sel < 35) begin
                    cmd = CMD_CHECK;
                    mr  = MOD_W'($urandom_range(0, 3));
                end
                else if (sel < 42) begin
                    cmd = CMD_KICK;
                    mr  = NO_MODULE;
                end
                else begin
                    cmd = CMD_KICK;
                    mr  = MOD_W'($urandom_range(0, MODULES - 1));
                    if (mr == victim && $urandom_range(0, 3) != 0)
                        mr = MOD_W'((mr + 1) % MODULES);
                end
                send_item(cmd, mr, stamp, 1'b0, '0);
            end
            item_valid <= 1'b0;
        end

        drain_results();
        if (mismatch_cnt == 0)
            $display("multi_module_liveness_watchdog_core verification clean");
        else
            $display("multi_module_liveness_watchdog_core verification failed");
        $finish;
    end

    initial begin
        wd_status_t  want;
        int unsigned hold;
        @(posedge rst_n);
        forever begin
            hold = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (hold > 0) begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected result item, none pending", $time);
                mismatch_cnt++;
            end
            else begin
                want = pending_status.pop_front();
                if (reboot !== want.reboot) begin
                    $display("%0t: reboot exp %0d got %0d", $time, want.reboot, reboot);
                    mismatch_cnt++;
                end
                if (reboot_module !== want.reboot_module) begin
                    $display("%0t: reboot_module exp %0d got %0d", $time,
                             want.reboot_module, reboot_module);
                    mismatch_cnt++;
                end
                if (error_mask !== want.error_mask) begin
                    $display("%0t: error_mask exp %b got %b", $time,
                             want.error_mask, error_mask);
                    mismatch_cnt++;
                end
                if (remembered_failure !== want.remembered_failure) begin
                    $display("%0t: remembered_failure exp %0d got %0d", $time,
                             want.remembered_failure, remembered_failure);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("multi_module_liveness_watchdog_core verification failed");
        $finish;
    end

endmodule
